// ===== rtl/core/squared_amplitude_sum_tree_core_assert.svh =====
// Assertion macros shared by the sum tree checker.
`ifndef SQUARED_AMPLITUDE_SUM_TREE_CORE_ASSERT_SVH
`define SQUARED_AMPLITUDE_SUM_TREE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SAST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SAST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sast_pkg.sv =====
// Shared constants and types of the squared amplitude sum tree.
package sast_pkg;

    localparam int MAX_LEVELS = 10;
    localparam int DATA_BITS  = 16;

    localparam int LEAF_W = 16;
    localparam int CFG_W  = 4;
    localparam int POS_W  = MAX_LEVELS + 1;
    localparam int VAL_W  = 41;
    localparam int CNT_W  = MAX_LEVELS;
    localparam int SQ_W   = 2 * DATA_BITS;
    localparam int AW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int LEVELS_RESET = 10;

    localparam int OUT_DATA_BITS = POS_W + VAL_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Write port of the pending sum memory.
    typedef struct packed {
        logic             we;
        logic [AW-1:0]    addr;
        logic [VAL_W-1:0] data;
    } t_psum_wr;

endpackage

// ===== rtl/core/sast_psum_ram.sv =====
// Pending left sum memory: one write port, one registered read port.
module sast_psum_ram (
    input  logic                        i_clk,
    input  sast_pkg::t_psum_wr          i_wr,
    input  logic [sast_pkg::AW-1:0]     i_raddr,
    output logic [sast_pkg::VAL_W-1:0]  o_rdata
);

    logic [sast_pkg::VAL_W-1:0] r_mem [sast_pkg::MAX_LEVELS];
    logic [sast_pkg::VAL_W-1:0] r_rdata;

    // Write side.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read side, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sast_square.sv =====
// Leaf square unit: takes the magnitude of a signed leaf and squares it.
module sast_square (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic [sast_pkg::DATA_BITS-1:0] i_raw,
    output logic [sast_pkg::SQ_W-1:0]      o_sq
);

    logic [sast_pkg::DATA_BITS-1:0] r_mag;
    logic [sast_pkg::DATA_BITS-1:0] n_mag;
    logic [sast_pkg::SQ_W-1:0]      r_sq;

    // Magnitude of the two's complement leaf; the most negative value fits unsigned.
    always_comb begin
        n_mag = i_raw[sast_pkg::DATA_BITS-1] ? (~i_raw + 1'b1) : i_raw;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= n_mag;
        end
    end

    // Registered product; it holds while the magnitude holds.
    always_ff @(posedge i_clk) begin
        r_sq <= sast_pkg::SQ_W'(r_mag) * sast_pkg::SQ_W'(r_mag);
    end

    assign o_sq = r_sq;

endmodule

// ===== rtl/core/squared_amplitude_sum_tree_core.sv =====
// A leaf word is registered and leaves in the cycle after its input word is accepted.
// Each leaf passes through the accept, the square state and one level state per internal
// node it completes (trailing ones of its index, at most the depth); one memory read per level.
// It then parks its left sum and returns to idle; the leaf that completes the root parks none.
// Output stalls hold the walk; a new leaf is accepted only in idle, after the last one is done.
// Reset (synchronous, active low) clears the leaf counter, sets depth to 10 and
// empties the output register; the pending sum memory is not cleared.
module squared_amplitude_sum_tree_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: depth register.
    input  logic                              i_cfg_we,
    input  logic [sast_pkg::CFG_W-1:0]        i_cfg_wdata,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sast_pkg::LEAF_W-1:0]       s_axis_tdata,   // [15:0] leaf_value
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sast_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // node_position, node_value, zeros
    output logic                              m_axis_tlast,   // run_last
    output logic                              m_axis_tuser    // tree_done
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SQR  = 3'b010,
        S_LVL  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [sast_pkg::CFG_W-1:0] r_cfg;
    logic [sast_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [sast_pkg::CNT_W-1:0] r_bits, n_bits;
    logic [sast_pkg::AW-1:0]    r_k, n_k;
    logic [sast_pkg::LVL_W-1:0] r_l, n_l;
    logic [sast_pkg::POS_W-1:0] r_pos, n_pos;
    logic [sast_pkg::VAL_W-1:0] r_sum, n_sum;

    logic                       r_ovalid, n_ovalid;
    logic [sast_pkg::POS_W-1:0] r_opos, n_opos;
    logic [sast_pkg::VAL_W-1:0] r_oval, n_oval;
    logic                       r_olast, n_olast;
    logic                       r_odone, n_odone;

    logic [sast_pkg::LVL_W-1:0] depth;
    logic [sast_pkg::POS_W-1:0] leaves;
    logic [sast_pkg::CNT_W-1:0] idx;
    logic [sast_pkg::CNT_W-1:0] bits_next;
    logic [sast_pkg::VAL_W-1:0] sum_op;
    logic [sast_pkg::VAL_W-1:0] node_sum;
    logic [sast_pkg::SQ_W-1:0]  sq;
    logic [sast_pkg::VAL_W-1:0] rdata;
    logic                       out_free;
    logic                       in_acc;
    logic                       top_lvl;
    sast_pkg::t_psum_wr         psum_wr;

    // Depth in use, clamped to one through the maximum.
    always_comb begin
        if (r_cfg == '0) begin
            depth = sast_pkg::LVL_W'(1);
        end else if (32'(r_cfg) > sast_pkg::MAX_LEVELS) begin
            depth = sast_pkg::LVL_W'(sast_pkg::MAX_LEVELS);
        end else begin
            depth = sast_pkg::LVL_W'(r_cfg);
        end
        leaves = sast_pkg::POS_W'(1) << depth;
        idx    = r_cnt & sast_pkg::CNT_W'(leaves - 1'b1);
    end

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    sast_square u_square (
        .i_clk  (i_clk),
        .i_load (in_acc),
        .i_raw  (s_axis_tdata[sast_pkg::DATA_BITS-1:0]),
        .o_sq   (sq)
    );

    sast_psum_ram u_psum (
        .i_clk   (i_clk),
        .i_wr    (psum_wr),
        .i_raddr (n_k),
        .o_rdata (rdata)
    );

    // The running sum starts from the square at the bottom level.
    assign sum_op    = (r_k == '0) ? sast_pkg::VAL_W'(sq) : r_sum;
    assign node_sum  = rdata + sum_op;
    assign bits_next = r_bits >> 1;
    assign top_lvl   = (sast_pkg::LVL_W'(r_k) + 1'b1) == r_l;

    // Sequencer: accept a leaf, square it, then walk up the levels.
    // Reads run one level ahead; the only write ends a leaf, so no access overlaps.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_bits   = r_bits;
        n_k      = r_k;
        n_l      = r_l;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_opos   = r_opos;
        n_oval   = r_oval;
        n_olast  = r_olast;
        n_odone  = r_odone;
        psum_wr  = '{we: 1'b0, addr: r_k, data: sum_op};

        case (r_state)
            S_IDLE: begin
                n_k = '0;
                if (in_acc) begin
                    n_bits   = idx;
                    n_l      = depth;
                    n_pos    = leaves | sast_pkg::POS_W'(idx);
                    n_cnt    = (idx + 1'b1) & sast_pkg::CNT_W'(leaves - 1'b1);
                    n_ovalid = 1'b1;
                    n_opos   = leaves | sast_pkg::POS_W'(idx);
                    n_oval   = sast_pkg::VAL_W'(s_axis_tdata[sast_pkg::DATA_BITS-1:0]);
                    n_olast  = !idx[0];
                    n_odone  = 1'b0;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                n_k     = '0;
                n_state = S_LVL;
            end
            S_LVL: begin
                if (!r_bits[0]) begin
                    // Left child: park the sum for its sibling.
                    psum_wr.we = 1'b1;
                    n_k        = '0;
                    n_state    = S_IDLE;
                end else if (out_free) begin
                    // Right child: the parent is complete.
                    n_sum    = node_sum;
                    n_pos    = r_pos >> 1;
                    n_bits   = bits_next;
                    n_ovalid = 1'b1;
                    n_opos   = r_pos >> 1;
                    n_oval   = node_sum;
                    n_olast  = top_lvl || !bits_next[0];
                    n_odone  = (r_pos >> 1) == sast_pkg::POS_W'(1);
                    if (top_lvl) begin
                        n_k     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_k     = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= sast_pkg::CFG_W'(sast_pkg::LEVELS_RESET);
            r_cnt    <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
                r_cnt <= '0;
            end else begin
                r_cnt <= n_cnt;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_l     <= n_l;
        r_pos   <= n_pos;
        r_sum   <= n_sum;
        r_opos  <= n_opos;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        r_odone <= n_odone;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = sast_pkg::OUT_TDATA_W'({r_oval, r_opos});
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_odone;

endmodule

// ===== rtl/core/sast_port_checker.sv =====
// Port-level checker for the sum tree core, bound to the top level.
`include "squared_amplitude_sum_tree_core_assert.svh"

module sast_port_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sast_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              m_axis_tuser
);

    logic root_word;
    logic root_pos;
    logic leaf_acc;
    logic out_stall;

    // Conditions seen on the ports.
    assign root_word = m_axis_tvalid && m_axis_tuser;
    assign root_pos  = m_axis_tdata[sast_pkg::POS_W-1:0] == sast_pkg::POS_W'(1);
    assign leaf_acc  = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // The root word always closes the run of its leaf.
    `SAST_ASSERT_NOW(a_root_is_last, i_clk, i_rst_n, root_word, m_axis_tlast, "root word without tlast")

    // The tree done flag only rides on heap position one.
    `SAST_ASSERT_NOW(a_root_pos, i_clk, i_rst_n, root_word, root_pos, "tree done away from root")

    // An accepted leaf shows up as an output word in the next cycle.
    `SAST_ASSERT_NEXT(a_leaf_out, i_clk, i_rst_n, leaf_acc, m_axis_tvalid,
                      "leaf word missing after accept")

    // A stalled output word holds.
    `SAST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
                      m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

endmodule

bind squared_amplitude_sum_tree_core sast_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
